FILE: src/dfdg_pkg.sv
// dfdg_pkg: shared types, constants and frame helpers for the dshot frame duty generator
// no dependencies; imported by every module of the block

package dfdg_pkg;

	localparam int LANES       = 4;
	localparam int FRAME_BITS  = 16;
	localparam int FRAME_ROWS  = 17;
	localparam int ROW_W       = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [10:0] MAX_VALUE    = 11'd2047;
	localparam logic [15:0] MIN_THROTTLE = 16'd48;
	localparam logic [15:0] MAX_COMMAND  = 16'd47;
	localparam logic [ROW_W-1:0] IDLE_ROW = ROW_W'(FRAME_ROWS - 1);

	localparam logic [2:0] REG_ENABLED      = 3'd0;
	localparam logic [2:0] REG_ALL_CHANNELS = 3'd1;
	localparam logic [2:0] REG_SELECTED     = 3'd2;
	localparam logic [2:0] REG_ZERO_DUTY    = 3'd3;
	localparam logic [2:0] REG_ONE_DUTY     = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_READY = 2'd1;
	localparam logic [1:0] STATUS_BAD_PARAM = 2'd2;

	typedef struct packed {
		logic        enabled;
		logic        all_channels;
		logic [1:0]  selected_channel;
		logic [15:0] zero_duty;
		logic [15:0] one_duty;
	} cfg_t;

	typedef struct packed {
		logic [LANES-1:0][FRAME_BITS-1:0] frames;
		logic [LANES-1:0]                 active;
		logic                             err;
		logic [1:0]                       code;
	} entry_t;

	typedef struct packed {
		logic [LANES-1:0][15:0] duty;
		logic                   last;
		logic [1:0]             status;
	} row_t;

	function automatic logic [10:0] clamp_level(input logic [15:0] v);
		logic [10:0] r;
		if (v == 16'd0) begin
			r = 11'd0;
		end else if (v < MIN_THROTTLE) begin
			r = MIN_THROTTLE[10:0];
		end else if (v > {5'd0, MAX_VALUE}) begin
			r = MAX_VALUE;
		end else begin
			r = v[10:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] build_frame(input logic [10:0] v, input logic telem);
		logic [11:0] w;
		logic [3:0]  crc;
		w   = {v, telem};
		crc = w[3:0] ^ w[7:4] ^ w[11:8];
		return {w, crc};
	endfunction

endpackage

FILE: src/dfdg_front.sv
// dfdg_front: classifies a request and builds the per-channel frames
// depends on dfdg_pkg

module dfdg_front import dfdg_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  cfg_t        cfg,
	input  logic        func,
	input  logic [15:0] level0,
	input  logic [15:0] level1,
	input  logic [15:0] level2,
	input  logic [15:0] level3,
	input  logic [3:0]  telem_req,
	output entry_t      entry
);

	localparam logic [2:0] CH_N = 3'(CHANNELS);

	logic [LANES-1:0][15:0] levels;

	assign levels = {level3, level2, level1, level0};

	always_comb begin
		entry        = '0;
		entry.frames = '0;
		if (!cfg.enabled) begin
			entry.err  = 1'b1;
			entry.code = STATUS_NOT_READY;
		end else if (cfg.all_channels) begin
			if (func) begin
				entry.err  = 1'b1;
				entry.code = STATUS_NOT_READY;
			end else begin
				for (int ch = 0; ch < LANES; ch++) begin
					if (ch < CHANNELS) begin
						entry.frames[ch] = build_frame(clamp_level(levels[ch]), telem_req[ch]);
						entry.active[ch] = 1'b1;
					end
				end
			end
		end else if ({1'b0, cfg.selected_channel} >= CH_N) begin
			entry.err  = 1'b1;
			entry.code = STATUS_BAD_PARAM;
		end else if (func && (level0 > MAX_COMMAND)) begin
			entry.err  = 1'b1;
			entry.code = STATUS_BAD_PARAM;
		end else begin
			entry.active[cfg.selected_channel] = 1'b1;
			if (func) begin
				entry.frames[cfg.selected_channel] = build_frame(level0[10:0], 1'b0);
			end else begin
				entry.frames[cfg.selected_channel] =
					build_frame(clamp_level(level0), telem_req[0]);
			end
		end
	end

endmodule

FILE: src/dfdg_queue.sv
// dfdg_queue: short word queue between the front and the row sequencer
// depends on dfdg_pkg

module dfdg_queue import dfdg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/dfdg_back.sv
// dfdg_back: row sequencer that turns queued frames into compare-value rows
// depends on dfdg_pkg

module dfdg_back import dfdg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   empty,
	input  entry_t head,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output row_t   row
);

	logic [ROW_W-1:0] row_q;
	logic             out_valid_q;
	row_t             row_out_q;
	row_t             row_next;
	logic             load;
	logic [3:0]       bit_idx;

	assign load    = !empty && (!out_valid_q || out_ready);
	assign pop     = load && (head.err || (row_q == IDLE_ROW));
	assign bit_idx = 4'd15 - row_q[3:0];

	always_comb begin
		row_next = '0;
		if (head.err) begin
			row_next.last   = 1'b1;
			row_next.status = head.code;
		end else if (row_q == IDLE_ROW) begin
			row_next.last   = 1'b1;
			row_next.status = STATUS_OK;
		end else begin
			for (int ch = 0; ch < LANES; ch++) begin
				if (head.active[ch]) begin
					row_next.duty[ch] = head.frames[ch][bit_idx] ? cfg.one_duty : cfg.zero_duty;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				row_q       <= pop ? '0 : row_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_out_q <= row_next;
		end
	end

	assign out_valid = out_valid_q;
	assign row       = row_out_q;

endmodule

FILE: src/dshot_frame_duty_generator.sv
// dshot_frame_duty_generator: top level with config registers, front, queue and row sequencer
// depends on dfdg_pkg, dfdg_front, dfdg_queue, dfdg_back

// Each accepted request yields seventeen rows of per-channel timer compare values, one row
// per cycle when the output side keeps ready high: sixteen frame bits MSB first and a final
// idle row marked last; a rejected request yields a single error row with last set. The row
// sequencer in the back end sets the rate, and a two-word queue lets the front take the
// next request while a frame is still being sent. A request is first written into the queue;
// its first row is then registered in the row sequencer's output register. Configuration
// must be written only while no request is in flight.

module dshot_frame_duty_generator import dfdg_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] level0,
	input  logic [15:0] level1,
	input  logic [15:0] level2,
	input  logic [15:0] level3,
	input  logic [3:0]  telem_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] duty0,
	output logic [15:0] duty1,
	output logic [15:0] duty2,
	output logic [15:0] duty3,
	output logic        last,
	output logic [1:0]  status
);

	cfg_t   cfg_q;
	entry_t entry;
	entry_t head;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	row_t   row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ENABLED:      cfg_q.enabled          <= cfg_wdata[0];
				REG_ALL_CHANNELS: cfg_q.all_channels     <= cfg_wdata[0];
				REG_SELECTED:     cfg_q.selected_channel <= cfg_wdata[1:0];
				REG_ZERO_DUTY:    cfg_q.zero_duty        <= cfg_wdata;
				REG_ONE_DUTY:     cfg_q.one_duty         <= cfg_wdata;
				default:          cfg_q                  <= cfg_q;
			endcase
		end
	end

	dfdg_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.cfg        (cfg_q),
		.func       (func),
		.level0     (level0),
		.level1     (level1),
		.level2     (level2),
		.level3     (level3),
		.telem_req  (telem_req),
		.entry      (entry)
	);

	dfdg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (entry),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head)
	);

	dfdg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (q_empty),
		.head      (head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row       (row)
	);

	assign in_ready = !q_full;
	assign duty0    = row.duty[0];
	assign duty1    = row.duty[1];
	assign duty2    = row.duty[2];
	assign duty3    = row.duty[3];
	assign last     = row.last;
	assign status   = row.status;

endmodule
